FILE: rtl/ssd_pkg.sv
// Shared constants for the seven-segment scan driver: segment codes and the
// reciprocal tables used for binary to decimal digit extraction.
// No dependencies.
package ssd_pkg;

  localparam int unsigned CODE_W = 4;
  localparam int unsigned SEG_W = 8;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned DEC_TBL_LEN = 9;

  localparam logic [CODE_W-1:0] MINUS_CODE = 4'd10;
  localparam logic [SEG_W-1:0] SEG_OFF = 8'hFF;

  // floor(v / 10^k) = (v * RECIP_MUL[k]) >> RECIP_SHIFT[k], exact for 16-bit v.
  // Beyond 10^4 the quotient of a 16-bit value is zero.
  localparam logic [16:0] RECIP_MUL [DEC_TBL_LEN] = '{
    17'd1, 17'd104858, 17'd83887, 17'd67109, 17'd107375,
    17'd0, 17'd0, 17'd0, 17'd0
  };
  localparam logic [4:0] RECIP_SHIFT [DEC_TBL_LEN] = '{
    5'd0, 5'd20, 5'd23, 5'd26, 5'd30, 5'd0, 5'd0, 5'd0, 5'd0
  };

  function automatic logic [SEG_W-1:0] seg_lookup(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      4'd0:    seg = 8'h06;
      4'd1:    seg = 8'h5F;
      4'd2:    seg = 8'h2C;
      4'd3:    seg = 8'hA4;
      4'd4:    seg = 8'hC5;
      4'd5:    seg = 8'h94;
      4'd6:    seg = 8'h54;
      4'd7:    seg = 8'hA7;
      4'd8:    seg = 8'h04;
      4'd9:    seg = 8'h84;
      default: seg = 8'hFD;
    endcase
    return seg;
  endfunction

endpackage

FILE: rtl/seven_segment_scan_driver_top.sv
// Seven-segment scan driver, top level.
// Holds the job state, decimal digit extraction and the scan sequencer.
// Depends on ssd_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per
//   request: a dwell tick, show value, show minus or start countdown.
//   Every transaction yields exactly one result on the output channel
//   (out_valid_o / out_stall_i): digit select, segment byte and busy flag.
//   A tick while a job runs drives the next digit; commands and idle ticks
//   return all segments off with the last select held.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are always taken and set
//   the countdown rounds per count (index 0) and final minus rounds (index 1).
// Timing:
//   One transaction per cycle sustained while the output is not stalled. A
//   transaction taken into the input register goes through the update logic
//   into the result register and is presented from there on.
// Reset:
//   Idle, all digits zero, select zero, rounds per count 2, final minus 50.
// Stall:
//   A stalled result holds; the input register keeps taking transactions
//   until it also holds one, after which in_stall_o is raised.
module seven_segment_scan_driver_top
  import ssd_pkg::*;
#(
  parameter int unsigned DIGITS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [VAL_W-1:0]  value_i,
  input  logic [VAL_W-1:0]  scan_rounds_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DIGITS-1:0] digit_select_o,
  output logic [SEG_W-1:0]  segments_o,
  output logic              busy_res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [VAL_W-1:0]  cfg_data_i
);

  localparam int unsigned PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_VALUE = 2'd1;
  localparam logic [1:0] REQ_MINUS = 2'd2;
  localparam logic [1:0] REQ_COUNT = 2'd3;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_VALUE = 2'd1;
  localparam logic [1:0] MODE_MINUS = 2'd2;
  localparam logic [1:0] MODE_COUNT = 2'd3;

  localparam logic CFG_RPC = 1'b0;
  localparam logic CFG_FMR = 1'b1;

  // input register
  logic             s1_vld_q;
  logic [1:0]       s1_req_q;
  logic [VAL_W-1:0] s1_val_q;
  logic [VAL_W-1:0] s1_rounds_q;

  // job state
  logic [CODE_W-1:0] digits_q [DIGITS];
  logic [CODE_W-1:0] digits_d [DIGITS];
  logic [PW-1:0]     pos_q, pos_d;
  logic [VAL_W-1:0]  rounds_q, rounds_d;
  logic [1:0]        mode_q, mode_d;
  logic [VAL_W-1:0]  count_q, count_d;
  logic [DIGITS-1:0] last_sel_q, last_sel_d;
  logic [VAL_W-1:0]  rpc_q, fmr_q;

  // result register
  logic              out_vld_q;
  logic [DIGITS-1:0] out_sel_q, sel;
  logic [SEG_W-1:0]  out_seg_q, seg;
  logic              out_busy_q;

  logic in_acc, advance, do_count;
  logic [VAL_W-1:0]  conv_in, cnt_n, rnd_dec;
  logic [VAL_W-1:0]  quo [DIGITS+1];
  logic [CODE_W-1:0] dec [DIGITS];

  assign advance    = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign cnt_n   = (s1_req_q == REQ_COUNT) ? s1_val_q : count_q - 16'd1;
  assign conv_in = (s1_req_q == REQ_TICK) ? cnt_n : s1_val_q;

  // quotients by powers of ten, then one digit per position (leftmost most significant)
  always_comb begin
    for (int k = 0; k <= DIGITS; k++) begin
      quo[k] = VAL_W'((33'(conv_in) * 33'(RECIP_MUL[k])) >> RECIP_SHIFT[k]);
    end
    for (int j = 0; j < DIGITS; j++) begin
      dec[j] = CODE_W'(quo[DIGITS-1-j]
                       - ((quo[DIGITS-j] << 3) + (quo[DIGITS-j] << 1)));
    end
  end

  assign rnd_dec = (rounds_q != '0) ? rounds_q - 16'd1 : rounds_q;

  always_comb begin
    digits_d   = digits_q;
    pos_d      = pos_q;
    rounds_d   = rounds_q;
    mode_d     = mode_q;
    count_d    = count_q;
    last_sel_d = last_sel_q;
    sel        = last_sel_q;
    seg        = SEG_OFF;
    do_count   = 1'b0;
    unique case (s1_req_q)
      REQ_VALUE: begin
        digits_d = dec;
        pos_d    = '0;
        rounds_d = s1_rounds_q;
        mode_d   = (s1_rounds_q == '0) ? MODE_IDLE : MODE_VALUE;
      end
      REQ_MINUS: begin
        for (int j = 0; j < DIGITS; j++) digits_d[j] = MINUS_CODE;
        pos_d    = '0;
        rounds_d = s1_rounds_q;
        mode_d   = (s1_rounds_q == '0) ? MODE_IDLE : MODE_MINUS;
      end
      REQ_COUNT: begin
        do_count = 1'b1;
      end
      default: begin
        if (mode_q != MODE_IDLE) begin
          sel        = DIGITS'(1) << pos_q;
          seg        = seg_lookup(digits_q[pos_q]);
          last_sel_d = sel;
          if (pos_q == PW'(DIGITS - 1)) begin
            pos_d    = '0;
            rounds_d = rnd_dec;
            if (rnd_dec == '0) begin
              if (mode_q == MODE_COUNT) begin
                do_count = 1'b1;
              end else begin
                mode_d = MODE_IDLE;
              end
            end
          end else begin
            pos_d = pos_q + PW'(1);
          end
        end
      end
    endcase
    if (do_count) begin
      pos_d = '0;
      if (cnt_n == '0 || rpc_q == '0) begin
        count_d = '0;
        for (int j = 0; j < DIGITS; j++) digits_d[j] = MINUS_CODE;
        rounds_d = fmr_q;
        mode_d   = (fmr_q == '0) ? MODE_IDLE : MODE_MINUS;
      end else begin
        count_d  = cnt_n;
        digits_d = dec;
        rounds_d = rpc_q;
        mode_d   = MODE_COUNT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (advance) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q    <= req_type_i;
      s1_val_q    <= value_i;
      s1_rounds_q <= scan_rounds_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < DIGITS; j++) digits_q[j] <= '0;
      pos_q      <= '0;
      rounds_q   <= '0;
      mode_q     <= MODE_IDLE;
      count_q    <= '0;
      last_sel_q <= '0;
    end else if (advance) begin
      digits_q   <= digits_d;
      pos_q      <= pos_d;
      rounds_q   <= rounds_d;
      mode_q     <= mode_d;
      count_q    <= count_d;
      last_sel_q <= last_sel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpc_q <= 16'd2;
      fmr_q <= 16'd50;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_RPC) begin
        rpc_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_FMR) begin
        fmr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_sel_q  <= sel;
      out_seg_q  <= seg;
      out_busy_q <= (mode_d != MODE_IDLE);
    end
  end

  assign out_valid_o    = out_vld_q;
  assign digit_select_o = out_sel_q;
  assign segments_o     = out_seg_q;
  assign busy_res_o     = out_busy_q;

endmodule
